// File: rtl/vau_pkg.sv
// Shared types and constants for the 3D vector arithmetic unit.
// Request and result payload structs, operation codes, saturation helper.
// No dependencies.
`default_nettype none

package vau_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned WIDE_W      = 66;
  localparam int unsigned SQRT_STAGES = 32;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = -66'sd2147483648;

  typedef enum logic [3:0] {
    MODE_NEG   = 4'd0,
    MODE_ADD_S = 4'd1,
    MODE_SUB_S = 4'd2,
    MODE_MUL_S = 4'd3,
    MODE_DIV_S = 4'd4,
    MODE_ADD_V = 4'd5,
    MODE_SUB_V = 4'd6,
    MODE_LEN   = 4'd7,
    MODE_NORM  = 4'd8,
    MODE_DOT   = 4'd9,
    MODE_CROSS = 4'd10
  } mode_e;

  typedef struct packed {
    logic [3:0]               mode;
    logic signed [DATA_W-1:0] ax;
    logic signed [DATA_W-1:0] ay;
    logic signed [DATA_W-1:0] az;
    logic signed [DATA_W-1:0] bx;
    logic signed [DATA_W-1:0] by;
    logic signed [DATA_W-1:0] bz;
    logic signed [DATA_W-1:0] scalar_in;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    logic signed [DATA_W-1:0] rz;
    logic signed [DATA_W-1:0] scalar_out;
    logic                     error;
    logic                     saturated;
  } out_t;

  // Clamped 32-bit value plus a flag that says whether clamping happened
  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(logic signed [WIDE_W-1:0] v);
    sat_t r;
    r.sat = 1'b0;
    r.val = v[DATA_W-1:0];
    if (v > WIDE_MAX) begin
      r.sat = 1'b1;
      r.val = WIDE_MAX[DATA_W-1:0];
    end else if (v < WIDE_MIN) begin
      r.sat = 1'b1;
      r.val = WIDE_MIN[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/vau_lane.sv
// One component lane: products, add/sub forms, rounding and clamping.
// Two register stages. Uses vau_pkg.
`default_nettype none

module vau_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [3:0]                        mode_i,
  input  logic signed [vau_pkg::DATA_W-1:0] a_i,
  input  logic signed [vau_pkg::DATA_W-1:0] b_i,
  input  logic signed [vau_pkg::DATA_W-1:0] s_i,
  input  logic signed [vau_pkg::DATA_W-1:0] aj_i,
  input  logic signed [vau_pkg::DATA_W-1:0] bk_i,
  input  logic signed [vau_pkg::DATA_W-1:0] ak_i,
  input  logic signed [vau_pkg::DATA_W-1:0] bj_i,
  output logic signed [2*vau_pkg::DATA_W-1:0] prod_o,
  output logic [vau_pkg::DATA_W-1:0]        res_o,
  output logic                              sat_o
);

  localparam int unsigned DW = vau_pkg::DATA_W;
  localparam int unsigned WW = vau_pkg::WIDE_W;
  localparam logic signed [WW-1:0] HALF = WW'(1) <<< (FRAC_BITS - 1);

  logic signed [DW-1:0]   mul_op;
  logic signed [DW:0]     addend;
  logic signed [DW:0]     simple_d;
  logic signed [2*DW-1:0] m1_q, c1_q, c2_q;
  logic signed [DW:0]     simple_q;
  logic [3:0]             mode_q;

  logic signed [WW-1:0]   wide;
  logic                   vec;
  vau_pkg::sat_t          fit;
  logic [DW-1:0]          res_q;
  logic                   sat_q;

  // product stage: one shared multiplier for scale, dot and square terms
  always_comb begin
    mul_op = a_i;
    if (mode_i == vau_pkg::MODE_MUL_S) begin
      mul_op = s_i;
    end else if (mode_i == vau_pkg::MODE_DOT) begin
      mul_op = b_i;
    end
    addend = (mode_i inside {vau_pkg::MODE_ADD_S, vau_pkg::MODE_SUB_S}) ?
             (DW+1)'(s_i) : (DW+1)'(b_i);
    case (mode_i)
      vau_pkg::MODE_ADD_S, vau_pkg::MODE_ADD_V: begin
        simple_d = (DW+1)'(a_i) + addend;
      end
      vau_pkg::MODE_SUB_S, vau_pkg::MODE_SUB_V: begin
        simple_d = (DW+1)'(a_i) - addend;
      end
      default: begin
        simple_d = -(DW+1)'(a_i);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q     <= a_i * mul_op;
      c1_q     <= aj_i * bk_i;
      c2_q     <= ak_i * bj_i;
      simple_q <= simple_d;
      mode_q   <= mode_i;
    end
  end

  // round products to nearest (halves up) and clamp
  always_comb begin
    vec  = 1'b1;
    wide = '0;
    case (mode_q)
      vau_pkg::MODE_NEG, vau_pkg::MODE_ADD_S, vau_pkg::MODE_SUB_S,
      vau_pkg::MODE_ADD_V, vau_pkg::MODE_SUB_V: begin
        wide = WW'(simple_q);
      end
      vau_pkg::MODE_MUL_S: begin
        wide = (WW'(m1_q) + HALF) >>> FRAC_BITS;
      end
      vau_pkg::MODE_CROSS: begin
        wide = (WW'(c1_q) - WW'(c2_q) + HALF) >>> FRAC_BITS;
      end
      default: begin
        vec = 1'b0;
      end
    endcase
    fit = vau_pkg::sat32(wide);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= vec ? fit.val : '0;
      sat_q <= vec & fit.sat;
    end
  end

  assign prod_o = m1_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;

endmodule

`default_nettype wire

// File: rtl/vau_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// floor(sqrt) of a 64-bit radicand. Uses vau_pkg.
`default_nettype none

module vau_isqrt (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [2*vau_pkg::SQRT_STAGES-1:0]   rad_i,
  output logic [vau_pkg::SQRT_STAGES-1:0]     root_o
);

  localparam int unsigned N    = vau_pkg::SQRT_STAGES;
  localparam int unsigned RADW = 2 * N;
  localparam int unsigned REMW = N + 2;

  logic [RADW-1:0] rad_q  [N];
  logic [REMW-1:0] rem_q  [N];
  logic [N-1:0]    root_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RADW-1:0] rad_in;
    logic [REMW-1:0] rem_in;
    logic [N-1:0]    root_in;
    logic [REMW+1:0] cur;
    logic [REMW+1:0] trial;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign cur   = {rem_in, rad_in[RADW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= {rad_in[RADW-3:0], 2'b00};
        if (cur >= trial) begin
          rem_q[k]  <= REMW'(cur - trial);
          root_q[k] <= {root_in[N-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cur[REMW-1:0];
          root_q[k] <= {root_in[N-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

`default_nettype wire

// File: rtl/vau_div_lane.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Divides |a| scaled by 2^FRAC_BITS by a 32-bit divisor. Uses vau_pkg.
`default_nettype none

module vau_div_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [vau_pkg::DATA_W-1:0]             num_i,
  input  logic [vau_pkg::DATA_W-1:0]             den_i,
  output logic [vau_pkg::DATA_W+FRAC_BITS-1:0]   quo_o
);

  localparam int unsigned DW = vau_pkg::DATA_W;
  localparam int unsigned NW = DW + FRAC_BITS;

  logic [NW-1:0] n_q   [NW];
  logic [NW-1:0] q_q   [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] n_in, q_in;
    logic [DW-1:0] rem_in, den_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign n_in   = {num_i, {FRAC_BITS{1'b0}}};
      assign q_in   = '0;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign n_in   = n_q[k-1];
      assign q_in   = q_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, n_in[NW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]   <= {n_in[NW-2:0], 1'b0};
        q_q[k]   <= {q_in[NW-2:0], ge};
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = q_q[NW-1];

endmodule

`default_nettype wire

// File: rtl/vector3_arithmetic_unit.sv
// 3D vector ALU in signed fixed point: three component lanes, square root and divide pipes.
// Uses vau_pkg, vau_lane, vau_isqrt, vau_div_lane.
// Pipeline: the entry register, two lane stages, 32 square-root steps,
// 32 + FRAC_BITS divide steps and the output register (FRAC_BITS is 16 for Q16.16).
// Throughput: one request per cycle while the output is not stalled,
// set by the fully pipelined root and divide steps.
// Reset: asynchronous, active low; clears all valid flags, payload registers are not reset.
`default_nettype none

module vector3_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vau_pkg::out_t out_data_o
);

  localparam int unsigned DW       = vau_pkg::DATA_W;
  localparam int unsigned WW       = vau_pkg::WIDE_W;
  localparam int unsigned NW       = DW + FRAC_BITS;
  localparam int unsigned DIV_AT   = vau_pkg::SQRT_STAGES;
  localparam int unsigned SIDE_LEN = DIV_AT + NW;
  localparam logic signed [WW-1:0] HALF = WW'(1) <<< (FRAC_BITS - 1);

  // Per-request data that rides alongside the root and divide pipes.
  // For the divide modes vec holds |a| per component, otherwise the lane results.
  typedef struct packed {
    logic [3:0]           mode;
    logic [2:0][DW-1:0]   vec;
    logic                 vsat;
    logic [DW-1:0]        sc;
    logic                 sc_sat;
    logic [2:0]           aneg;
    logic [DW-1:0]        smag;
    logic                 sneg;
    logic                 err;
  } side_t;

  function automatic logic [DW-1:0] mag(logic signed [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  // signed quotient: magnitude with sign applied, then clamped
  function automatic vau_pkg::sat_t fit_quo(logic [NW-1:0] q, logic neg);
    logic signed [WW-1:0] w;
    w = signed'(WW'(q));
    if (neg) begin
      w = -w;
    end
    return vau_pkg::sat32(w);
  endfunction

  // ---------------------------------------------------------------------
  // Flow control. One global advance: the whole pipe moves when the output
  // register is empty or being drained. A one-entry skid register in front
  // keeps in_ready_o registered and takes one more request while a result
  // is held at the output.
  // ---------------------------------------------------------------------
  logic          adv;
  logic          skid_valid_q;
  vau_pkg::in_t  skid_q;
  vau_pkg::in_t  entry;
  logic          entry_valid;

  assign adv         = !out_valid_o || out_ready_i;
  assign in_ready_o  = !skid_valid_q;
  assign entry       = skid_valid_q ? skid_q : in_data_i;
  assign entry_valid = skid_valid_q || in_valid_i;

  // stage registers: entry (e), product (p), rounding (r)
  vau_pkg::in_t          e_q, p_q, rin_q;
  logic                  e_valid_q, p_valid_q, r_valid_q;
  logic [SIDE_LEN-1:0]   side_valid_q;
  side_t                 side_q [SIDE_LEN];
  vau_pkg::out_t         out_q;
  logic                  out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
      e_valid_q    <= 1'b0;
      p_valid_q    <= 1'b0;
      r_valid_q    <= 1'b0;
      side_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (adv) begin
        skid_valid_q <= 1'b0;
        e_valid_q    <= entry_valid;
        p_valid_q    <= e_valid_q;
        r_valid_q    <= p_valid_q;
        side_valid_q <= {side_valid_q[SIDE_LEN-2:0], r_valid_q};
        out_valid_q  <= side_valid_q[SIDE_LEN-1];
      end else if (in_valid_i && in_ready_o) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q   <= entry;
      p_q   <= e_q;
      rin_q <= p_q;
    end else if (in_valid_i && in_ready_o) begin
      skid_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------
  // Component lanes. Lane i also forms the cross term a[j]*b[k] - a[k]*b[j].
  // ---------------------------------------------------------------------
  logic signed [2*DW-1:0] prod [3];
  logic [DW-1:0]          lane_res [3];
  logic [2:0]             lane_sat;

  vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .mode_i (e_q.mode),
    .a_i    (e_q.ax),
    .b_i    (e_q.bx),
    .s_i    (e_q.scalar_in),
    .aj_i   (e_q.ay),
    .bk_i   (e_q.bz),
    .ak_i   (e_q.az),
    .bj_i   (e_q.by),
    .prod_o (prod[0]),
    .res_o  (lane_res[0]),
    .sat_o  (lane_sat[0])
  );

  vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .mode_i (e_q.mode),
    .a_i    (e_q.ay),
    .b_i    (e_q.by),
    .s_i    (e_q.scalar_in),
    .aj_i   (e_q.az),
    .bk_i   (e_q.bx),
    .ak_i   (e_q.ax),
    .bj_i   (e_q.bz),
    .prod_o (prod[1]),
    .res_o  (lane_res[1]),
    .sat_o  (lane_sat[1])
  );

  vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk_i  (clk_i),
    .en_i   (adv),
    .mode_i (e_q.mode),
    .a_i    (e_q.az),
    .b_i    (e_q.bz),
    .s_i    (e_q.scalar_in),
    .aj_i   (e_q.ax),
    .bk_i   (e_q.by),
    .ak_i   (e_q.ay),
    .bj_i   (e_q.bx),
    .prod_o (prod[2]),
    .res_o  (lane_res[2]),
    .sat_o  (lane_sat[2])
  );

  // ---------------------------------------------------------------------
  // Merge of the lane products: dot product (rounded, clamped) and the sum
  // of squares for length and normalise. Sits beside the lanes' round stage.
  // ---------------------------------------------------------------------
  logic signed [WW-1:0] dot_sum;
  vau_pkg::sat_t        dot_fit, dot_q;
  logic [2*DW-1:0]      sumsq_d, sumsq_q;

  always_comb begin
    dot_sum = WW'(prod[0]) + WW'(prod[1]) + WW'(prod[2]);
    dot_fit = vau_pkg::sat32((dot_sum + HALF) >>> FRAC_BITS);
    // squares are non-negative and three of them stay below 2^64
    sumsq_d = $unsigned(prod[0]) + $unsigned(prod[1]) + $unsigned(prod[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dot_q   <= (p_q.mode == vau_pkg::MODE_DOT) ? dot_fit : '0;
      sumsq_q <= sumsq_d;
    end
  end

  // side data entering the long pipe
  side_t side_in;
  logic  in_div;

  always_comb begin
    in_div          = rin_q.mode inside {vau_pkg::MODE_DIV_S, vau_pkg::MODE_NORM};
    side_in.mode    = rin_q.mode;
    side_in.vec[0]  = in_div ? mag(rin_q.ax) : lane_res[0];
    side_in.vec[1]  = in_div ? mag(rin_q.ay) : lane_res[1];
    side_in.vec[2]  = in_div ? mag(rin_q.az) : lane_res[2];
    side_in.vsat    = |lane_sat;
    side_in.sc      = dot_q.val;
    side_in.sc_sat  = dot_q.sat;
    side_in.aneg    = {rin_q.az[DW-1], rin_q.ay[DW-1], rin_q.ax[DW-1]};
    side_in.smag    = mag(rin_q.scalar_in);
    side_in.sneg    = rin_q.scalar_in[DW-1];
    side_in.err     = (rin_q.mode == vau_pkg::MODE_DIV_S) && (rin_q.scalar_in == '0);
  end

  // ---------------------------------------------------------------------
  // Square root of the sum of squares: 32 pipelined steps.
  // ---------------------------------------------------------------------
  logic [DW-1:0] root;

  vau_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (sumsq_q),
    .root_o (root)
  );

  // Hand-over to the divide pipe: the length result is clamped here, and the
  // divisor is the scalar magnitude or the vector length.
  side_t         side_div;
  logic [DW-1:0] den;

  always_comb begin
    side_div = side_q[DIV_AT-1];
    den      = side_div.smag;
    if (side_div.mode == vau_pkg::MODE_LEN) begin
      side_div.sc     = root[DW-1] ? vau_pkg::WIDE_MAX[DW-1:0] : root;
      side_div.sc_sat = root[DW-1];
    end else if (side_div.mode == vau_pkg::MODE_NORM) begin
      den          = root;
      side_div.err = (root == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k < SIDE_LEN; k++) begin
        side_q[k] <= (k == DIV_AT) ? side_div : side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Divide lanes: |a| * 2^FRAC_BITS / divisor, truncated; sign applied after.
  // ---------------------------------------------------------------------
  logic [NW-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    vau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (side_div.vec[i]),
      .den_i (den),
      .quo_o (quo[i])
    );
  end

  // ---------------------------------------------------------------------
  // Final merge: pick lane or divide results, apply error and flags.
  // ---------------------------------------------------------------------
  side_t         fin;
  vau_pkg::sat_t qfit [3];
  logic          dneg;
  logic          fin_div;
  vau_pkg::out_t out_d;

  always_comb begin
    fin     = side_q[SIDE_LEN-1];
    fin_div = fin.mode inside {vau_pkg::MODE_DIV_S, vau_pkg::MODE_NORM};
    dneg    = (fin.mode == vau_pkg::MODE_DIV_S) && fin.sneg;
    for (int i = 0; i < 3; i++) begin
      qfit[i] = fit_quo(quo[i], fin.aneg[i] ^ dneg);
    end

    out_d.rx         = fin.vec[0];
    out_d.ry         = fin.vec[1];
    out_d.rz         = fin.vec[2];
    out_d.scalar_out = fin.sc;
    out_d.error      = 1'b0;
    out_d.saturated  = fin.vsat | fin.sc_sat;

    if (fin.err) begin
      // zero divisor or zero-length vector: everything zero, error raised
      out_d            = '0;
      out_d.error      = 1'b1;
    end else if (fin_div) begin
      out_d.rx        = qfit[0].val;
      out_d.ry        = qfit[1].val;
      out_d.rz        = qfit[2].val;
      out_d.saturated = qfit[0].sat | qfit[1].sat | qfit[2].sat | fin.sc_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: tb/sv/vector3_arithmetic_unit_tb.sv
// Self-checking bench for the Q16.16 3D vector arithmetic unit: directed corners, then
// weighted random requests under bursty input and a stalling output, checked in order.
// Depends on vau_pkg and vector3_arithmetic_unit.
`timescale 1ns / 1ps

module vector3_arithmetic_unit_tb;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 1850;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;  // longer than the pipeline depth
  localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (FRAC - 1);
  localparam logic signed [127:0] ONE_Q = 128'sd1 <<< FRAC;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  vau_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  vau_pkg::out_t out_data_o;

  vau_pkg::in_t  pending_reqs[$];
  vau_pkg::out_t expected_results[$];
  int   issued_cnt = 0;
  int   accepted_cnt = 0;
  int   cycle_cnt = 0;
  bit   failed = 1'b0;

  vector3_arithmetic_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp_q(logic signed [127:0] v, inout bit sat);
    if (v > Q_MAX) begin
      sat = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      sat = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // Expected result of one request
  function automatic vau_pkg::out_t vector_op_result(vau_pkg::in_t q);
    logic signed [127:0] a[3], b[3], r[3], s, sc, p;
    longint unsigned sumsq, len;
    bit err, sat, vec;
    vau_pkg::out_t o;
    a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
    b[0] = q.bx; b[1] = q.by; b[2] = q.bz;
    s = q.scalar_in;
    r[0] = 0; r[1] = 0; r[2] = 0;
    sc = 0;
    err = 0; sat = 0; vec = 0;
    case (q.mode)
      vau_pkg::MODE_NEG: begin
        for (int i = 0; i < 3; i++) r[i] = -a[i];
        vec = 1;
      end
      vau_pkg::MODE_ADD_S: begin
        for (int i = 0; i < 3; i++) r[i] = a[i] + s;
        vec = 1;
      end
      vau_pkg::MODE_SUB_S: begin
        for (int i = 0; i < 3; i++) r[i] = a[i] - s;
        vec = 1;
      end
      vau_pkg::MODE_MUL_S: begin
        for (int i = 0; i < 3; i++) r[i] = (a[i] * s + HALF_LSB) >>> FRAC;
        vec = 1;
      end
      vau_pkg::MODE_DIV_S: begin
        if (s == 0) err = 1;
        else begin
          for (int i = 0; i < 3; i++) r[i] = (a[i] * ONE_Q) / s;
          vec = 1;
        end
      end
      vau_pkg::MODE_ADD_V: begin
        for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
        vec = 1;
      end
      vau_pkg::MODE_SUB_V: begin
        for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
        vec = 1;
      end
      vau_pkg::MODE_LEN, vau_pkg::MODE_NORM: begin
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
          p = a[i] * a[i];
          sumsq = sumsq + p[63:0];
        end
        len = root_floor(sumsq);
        if (q.mode == vau_pkg::MODE_LEN) sc = {64'd0, len};
        else if (len == 0) err = 1;
        else begin
          for (int i = 0; i < 3; i++) r[i] = (a[i] * ONE_Q) / $signed({64'd0, len});
          vec = 1;
        end
      end
      vau_pkg::MODE_DOT: sc = (a[0] * b[0] + a[1] * b[1] + a[2] * b[2] + HALF_LSB) >>> FRAC;
      vau_pkg::MODE_CROSS: begin
        for (int i = 0; i < 3; i++)
          r[i] = (a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3] + HALF_LSB) >>> FRAC;
        vec = 1;
      end
      default: ;
    endcase
    o.rx = vec ? clamp_q(r[0], sat) : '0;
    o.ry = vec ? clamp_q(r[1], sat) : '0;
    o.rz = vec ? clamp_q(r[2], sat) : '0;
    o.scalar_out = clamp_q(sc, sat);
    o.error = err;
    o.saturated = sat;
    return o;
  endfunction

  // Operand mix: corners, small magnitudes, full range
  function automatic logic [31:0] pick_q();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'sh00010000 : -32'sh00010000;
      4, 5: return $urandom_range(0, 1) ? $urandom_range(0, 32'hfffff)
                                          : -$urandom_range(0, 32'hfffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic vau_pkg::in_t make_req(logic [3:0] m, logic [31:0] ax, logic [31:0] ay,
                                            logic [31:0] az, logic [31:0] bx,
                                            logic [31:0] by, logic [31:0] bz,
                                            logic [31:0] s);
    vau_pkg::in_t q;
    q.mode = m; q.ax = ax; q.ay = ay; q.az = az;
    q.bx = bx; q.by = by; q.bz = bz; q.scalar_in = s;
    return q;
  endfunction

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, got_v);
      failed = 1'b1;
    end
  endtask

  // Stimulus
  initial begin
    vau_pkg::in_t q;
    // directed: every code, corners, divide by zero, zero-length normalise, negated minimum
    pending_reqs.push_back(make_req(vau_pkg::MODE_NEG, Q_MIN, Q_MAX, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_ADD_S, Q_MAX, Q_MIN, 5, 0, 0, 0, Q_MAX));
    pending_reqs.push_back(make_req(vau_pkg::MODE_SUB_S, Q_MIN, Q_MAX, 5, 0, 0, 0, Q_MAX));
    pending_reqs.push_back(make_req(vau_pkg::MODE_MUL_S, Q_MAX, Q_MIN, 32'h18000,
                                    0, 0, 0, Q_MIN));
    pending_reqs.push_back(make_req(vau_pkg::MODE_MUL_S, 32'h8000, -32'h8000, 1,
                                    0, 0, 0, 1));
    pending_reqs.push_back(make_req(vau_pkg::MODE_DIV_S, Q_MAX, Q_MIN, 7, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_DIV_S, Q_MAX, Q_MIN, -7, 0, 0, 0, 1));
    pending_reqs.push_back(make_req(vau_pkg::MODE_DIV_S, Q_MIN, 3, -7, 0, 0, 0, -1));
    pending_reqs.push_back(make_req(vau_pkg::MODE_ADD_V, Q_MAX, Q_MIN, 1,
                                    Q_MAX, Q_MIN, -1, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_SUB_V, Q_MAX, Q_MIN, 0,
                                    Q_MIN, Q_MAX, Q_MIN, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_LEN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_LEN, 32'h30000, 32'h40000, 0,
                                    0, 0, 0, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_NORM, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_NORM, 0, 0, 1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_NORM, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_DOT, Q_MIN, Q_MIN, Q_MIN,
                                    Q_MIN, Q_MIN, Q_MIN, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_DOT, Q_MAX, Q_MIN, 1,
                                    Q_MIN, Q_MAX, 1, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_CROSS, Q_MIN, Q_MAX, Q_MIN,
                                    Q_MAX, Q_MIN, Q_MAX, 0));
    pending_reqs.push_back(make_req(vau_pkg::MODE_CROSS, 32'h10000, 0, 0,
                                    0, 32'h10000, 0, 0));
    for (int m = 11; m < 16; m++)
      pending_reqs.push_back(make_req(4'(m), Q_MAX, Q_MIN, 1, 2, 3, 4, 5));
    // random
    for (int n = 0; n < N_RANDOM; n++) begin
      q = make_req(4'($urandom_range(0, 19) == 0 ? $urandom_range(11, 15)
                                                  : $urandom_range(0, 10)),
                   pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), pick_q());
      if (q.mode == vau_pkg::MODE_NORM && $urandom_range(0, 7) == 0) begin
        q.ax = 0; q.ay = 0; q.az = 0;
      end
      pending_reqs.push_back(q);
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Request driver: bursts of random length separated by random gaps
  always @(negedge clk_i) begin
    static int burst_left = 0;
    static int gap_left = 0;
    if (rst_ni && !(in_valid_i && accepted_cnt != issued_cnt)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_data_i <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        issued_cnt++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern picked at random from four styles; one long hold-off
  always @(negedge clk_i) begin
    static int style = 0;
    static int style_left = 0;
    static int hold_left = 0;
    static bit hold_done = 1'b0;
    if (!hold_done && accepted_cnt >= 400) begin
      hold_done = 1'b1;
      hold_left = 600;
    end
    if (style_left == 0) begin
      style = $urandom_range(0, 3);
      style_left = 50;
    end
    style_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (style)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1) != 0;
        2: out_ready_i <= $urandom_range(0, 4) != 0;
        default: out_ready_i <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // Monitor: predict on request acceptance, check on result acceptance
  always @(posedge clk_i) begin
    vau_pkg::out_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(vector_op_result(in_data_i));
        accepted_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_data_o);
          failed = 1'b1;
        end else begin
          exp_r = expected_results.pop_front();
          report_field("rx", exp_r.rx, out_data_o.rx);
          report_field("ry", exp_r.ry, out_data_o.ry);
          report_field("rz", exp_r.rz, out_data_o.rz);
          report_field("scalar_out", exp_r.scalar_out, out_data_o.scalar_out);
          report_field("error", exp_r.error, out_data_o.error);
          report_field("saturated", exp_r.saturated, out_data_o.saturated);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  // End of run
  initial begin
    wait (rst_ni);
    wait (pending_reqs.size() == 0 && accepted_cnt == issued_cnt
          && expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, expected_results.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/vau_pkg.sv
rtl/vau_lane.sv
rtl/vau_isqrt.sv
rtl/vau_div_lane.sv
rtl/vector3_arithmetic_unit.sv
tb/sv/vector3_arithmetic_unit_tb.sv
